// File: hdl/battery_thermal_charge_guard_unit_defines.svh
// Assertion macros shared by the guard RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BATTERY_THERMAL_CHARGE_GUARD_UNIT_DEFINES_SVH
`define BATTERY_THERMAL_CHARGE_GUARD_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check on every clock edge, skipped while reset is asserted.
`define BTCG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("battery guard assertion failed");

// Check on every clock edge, reset included.
`define BTCG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("battery guard assertion failed");

`else

`define BTCG_ASSERT(label, prop)
`define BTCG_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: hdl/btcg_pkg.sv
package btcg_pkg;

    // Rule set selected by the version register
    typedef enum logic [2:0] {
        VER_V18         = 3'd0,
        VER_V18_CARRIER = 3'd1,
        VER_V19         = 3'd2,
        VER_V20         = 3'd3,
        VER_V21         = 3'd4
    } ver_t;

    // Thermal levels
    typedef enum logic [2:0] {
        TH_COLD     = 3'd0,
        TH_COOL     = 3'd1,
        TH_NORMAL   = 3'd2,
        TH_HIGH     = 3'd3,
        TH_OVERHEAT = 3'd4
    } thermal_t;

    // Health codes
    typedef enum logic [1:0] {
        HEALTH_GOOD     = 2'd0,
        HEALTH_OVERHEAT = 2'd1,
        HEALTH_COLD     = 2'd2
    } health_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_VERSION      = 2'd0,
        REG_FCC_LIMIT    = 2'd1,
        REG_VFLOAT_LIMIT = 2'd2
    } reg_idx_t;

    localparam int PADDR_W = 4;

    // Input and register limits
    localparam logic signed [10:0] TEMP_MIN    = -11'sd400;
    localparam logic signed [10:0] TEMP_MAX    = 11'sd1000;
    localparam logic [22:0]        VOLT_MAX_UV = 23'd5000000;
    localparam logic [11:0]        FCC_MAX     = 12'd4000;
    localparam logic [12:0]        VFLOAT_MAX  = 13'd5000;
    localparam logic [11:0]        FCC_RESET   = 12'd1000;
    localparam logic [12:0]        VFLOAT_RESET = 13'd4000;
    localparam logic [9:0]         UV_PER_MV   = 10'd1000;
    localparam logic [12:0]        COOL_HV_FCC = 13'd500;

    // No vote
    localparam logic signed [12:0] NO_VOTE_MA = -13'sd1;
    localparam logic signed [13:0] NO_VOTE_MV = -14'sd1;

    // Thermal thresholds, start and release, in 0.1 degC
    localparam logic signed [10:0] V18_OH_START   = 11'sd550;
    localparam logic signed [10:0] V18_OH_REL     = 11'sd520;
    localparam logic signed [10:0] V18_HI_START   = 11'sd450;
    localparam logic signed [10:0] V18_HI_REL     = 11'sd430;
    localparam logic signed [10:0] V18_COLD_START = -11'sd100;
    localparam logic signed [10:0] V18_COLD_REL   = -11'sd50;

    localparam logic signed [10:0] CAR_OH_START   = 11'sd530;
    localparam logic signed [10:0] CAR_OH_REL     = 11'sd520;
    localparam logic signed [10:0] CAR_HI_START   = 11'sd450;
    localparam logic signed [10:0] CAR_HI_REL     = 11'sd440;
    localparam logic signed [10:0] CAR_COLD_START = -11'sd50;
    localparam logic signed [10:0] CAR_COLD_REL   = -11'sd40;

    localparam logic signed [10:0] NEW_OH_START   = 11'sd550;
    localparam logic signed [10:0] NEW_OH_REL     = 11'sd520;
    localparam logic signed [10:0] NEW_HI_START   = 11'sd450;
    localparam logic signed [10:0] NEW_HI_REL     = 11'sd430;
    localparam logic signed [10:0] NEW_COLD_START = 11'sd0;
    localparam logic signed [10:0] NEW_COLD_REL   = 11'sd30;
    localparam logic signed [10:0] NEW_COOL_START = 11'sd100;
    localparam logic signed [10:0] NEW_COOL_REL   = 11'sd120;

    // Configuration seen by the datapath
    typedef struct packed {
        ver_t        version;
        logic [11:0] fcc_limit_ma;
        logic [12:0] vfloat_limit_mv;
        logic [22:0] vthr_uv;   // lowest voltage in uV that counts as high
    } cfg_t;

    // Enter a hot level above start, drop one level below release
    function automatic thermal_t hi_step(thermal_t st, logic signed [10:0] t,
                                         thermal_t lvl, logic signed [10:0] start,
                                         logic signed [10:0] rel);
        thermal_t s;
        s = st;
        if (t > start && s < lvl)
        begin
            s = lvl;
        end
        if (s == lvl && t < rel)
        begin
            s = thermal_t'(s - 3'd1);
        end
        return s;
    endfunction

    // Enter a cold level below start, rise one level above release
    function automatic thermal_t lo_step(thermal_t st, logic signed [10:0] t,
                                         thermal_t lvl, logic signed [10:0] start,
                                         logic signed [10:0] rel);
        thermal_t s;
        s = st;
        if (t < start && s > lvl)
        begin
            s = lvl;
        end
        if (s == lvl && t > rel)
        begin
            s = thermal_t'(s + 3'd1);
        end
        return s;
    endfunction

    // Next thermal level for a known version
    function automatic thermal_t thermal_next(ver_t ver, thermal_t st,
                                              logic signed [10:0] t);
        thermal_t s;
        s = st;
        if (ver == VER_V18)
        begin
            s = hi_step(s, t, TH_OVERHEAT, V18_OH_START, V18_OH_REL);
            s = hi_step(s, t, TH_HIGH, V18_HI_START, V18_HI_REL);
            s = lo_step(s, t, TH_COLD, V18_COLD_START, V18_COLD_REL);
        end
        else if (ver == VER_V18_CARRIER)
        begin
            s = hi_step(s, t, TH_OVERHEAT, CAR_OH_START, CAR_OH_REL);
            s = hi_step(s, t, TH_HIGH, CAR_HI_START, CAR_HI_REL);
            s = lo_step(s, t, TH_COLD, CAR_COLD_START, CAR_COLD_REL);
        end
        else
        begin
            s = hi_step(s, t, TH_OVERHEAT, NEW_OH_START, NEW_OH_REL);
            s = hi_step(s, t, TH_HIGH, NEW_HI_START, NEW_HI_REL);
            s = lo_step(s, t, TH_COLD, NEW_COLD_START, NEW_COLD_REL);
            s = lo_step(s, t, TH_COOL, NEW_COOL_START, NEW_COOL_REL);
        end
        // Older rule sets have no cool level
        if (ver <= VER_V18_CARRIER && s == TH_COOL)
        begin
            s = TH_NORMAL;
        end
        return s;
    endfunction

endpackage

// File: hdl/btcg_if.sv
// Battery sample channel
interface btcg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] temp_decideg;
    logic [22:0]        voltage_uv;

    modport source (output valid, output temp_decideg, output voltage_uv, input ready);
    modport sink (input valid, input temp_decideg, input voltage_uv, output ready);
endinterface

// Guard result channel
interface btcg_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         thermal_state;
    logic               voltage_high;
    logic [1:0]         health;
    logic signed [12:0] current_vote_ma;
    logic signed [13:0] float_vote_mv;

    modport source (output valid, output thermal_state, output voltage_high,
                    output health, output current_vote_ma, output float_vote_mv,
                    input ready);
    modport sink (input valid, input thermal_state, input voltage_high,
                  input health, input current_vote_ma, input float_vote_mv,
                  output ready);
endinterface

// File: hdl/btcg_cfg.sv
module btcg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btcg_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output btcg_pkg::cfg_t                 cfg
);

    btcg_pkg::ver_t    version_reg;
    logic [11:0]       fcc_reg;
    logic [12:0]       vfloat_reg;
    logic [22:0]       vthr_reg;
    logic [11:0]       fcc_sat;
    logic [12:0]       vfloat_sat;
    logic [22:0]       vthr_next;
    logic              wr_en;
    btcg_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = btcg_pkg::reg_idx_t'(paddr[3:2]);

    // Saturate written limits
    assign fcc_sat    = (pwdata[11:0] > btcg_pkg::FCC_MAX) ? btcg_pkg::FCC_MAX : pwdata[11:0];
    assign vfloat_sat = (pwdata[12:0] > btcg_pkg::VFLOAT_MAX) ?
                        btcg_pkg::VFLOAT_MAX : pwdata[12:0];
    // mV > limit holds exactly when uV >= (limit + 1) * 1000
    assign vthr_next  = 23'((23'(vfloat_sat) + 23'd1) * 23'(btcg_pkg::UV_PER_MV));

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= btcg_pkg::VER_V18;
            fcc_reg     <= btcg_pkg::FCC_RESET;
            vfloat_reg  <= btcg_pkg::VFLOAT_RESET;
            vthr_reg    <= 23'((23'(btcg_pkg::VFLOAT_RESET) + 23'd1)
                               * 23'(btcg_pkg::UV_PER_MV));
        end
        else if (wr_en)
        begin
            unique case (idx)
                btcg_pkg::REG_VERSION:
                begin
                    version_reg <= btcg_pkg::ver_t'(pwdata[2:0]);
                end
                btcg_pkg::REG_FCC_LIMIT:
                begin
                    fcc_reg <= fcc_sat;
                end
                btcg_pkg::REG_VFLOAT_LIMIT:
                begin
                    vfloat_reg <= vfloat_sat;
                    vthr_reg   <= vthr_next;
                end
                default:
                begin
                    // drop writes to unmapped addresses
                end
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            btcg_pkg::REG_VERSION:      prdata = 32'(version_reg);
            btcg_pkg::REG_FCC_LIMIT:    prdata = 32'(fcc_reg);
            btcg_pkg::REG_VFLOAT_LIMIT: prdata = 32'(vfloat_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.version         = version_reg;
    assign cfg.fcc_limit_ma    = fcc_reg;
    assign cfg.vfloat_limit_mv = vfloat_reg;
    assign cfg.vthr_uv         = vthr_reg;

endmodule

// File: hdl/btcg_front.sv
module btcg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    btcg_sample_if.sink          sample,
    input  logic [22:0]          vthr_uv,
    input  logic                 advance,
    output logic                 s1_valid,
    output logic signed [10:0]   s1_temp,
    output logic                 s1_vhigh
);

    logic               valid_reg;
    logic signed [10:0] temp_reg;
    logic               vhigh_reg;
    logic signed [10:0] temp_sat;
    logic [22:0]        uv_sat;
    logic               accept;

    // Take a request when the stage is empty or draining this cycle
    assign sample.ready = !valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    // Saturate temperature and voltage
    always_comb
    begin
        priority if (sample.temp_decideg < btcg_pkg::TEMP_MIN)
        begin
            temp_sat = btcg_pkg::TEMP_MIN;
        end
        else if (sample.temp_decideg > btcg_pkg::TEMP_MAX)
        begin
            temp_sat = btcg_pkg::TEMP_MAX;
        end
        else
        begin
            temp_sat = sample.temp_decideg;
        end
        uv_sat = (sample.voltage_uv > btcg_pkg::VOLT_MAX_UV) ?
                 btcg_pkg::VOLT_MAX_UV : sample.voltage_uv;
    end

    // Hold stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    // Load payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg  <= temp_sat;
            vhigh_reg <= (uv_sat >= vthr_uv);
        end
    end

    assign s1_valid = valid_reg;
    assign s1_temp  = temp_reg;
    assign s1_vhigh = vhigh_reg;

endmodule

// File: hdl/btcg_core.sv
`include "battery_thermal_charge_guard_unit_defines.svh"

module btcg_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  btcg_pkg::cfg_t       cfg,
    input  logic                 s1_valid,
    input  logic signed [10:0]   s1_temp,
    input  logic                 s1_vhigh,
    output logic                 advance,
    btcg_result_if.source        result
);

    btcg_pkg::thermal_t thermal_reg;
    btcg_pkg::thermal_t thermal_next;
    logic               volt_reg;
    logic               volt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    btcg_pkg::thermal_t st_new;
    logic               ver_ok;
    logic               update;
    logic               emit;
    btcg_pkg::health_t  health_c;
    logic signed [12:0] fcc_c;
    logic signed [13:0] vfl_c;
    btcg_pkg::thermal_t o_state_reg;
    logic               o_vhigh_reg;
    btcg_pkg::health_t  o_health_reg;
    logic signed [12:0] o_fcc_reg;
    logic signed [13:0] o_vfl_reg;

    // Move the sample on when the result slot is free or being taken
    assign advance = s1_valid && (!out_valid_reg || result.ready);
    assign ver_ok  = (cfg.version <= btcg_pkg::VER_V21);
    assign update  = advance && ver_ok;
    assign st_new  = btcg_pkg::thermal_next(cfg.version, thermal_reg, s1_temp);

    // Decide whether the change is worth reporting
    always_comb
    begin
        emit = (st_new != thermal_reg);
        if (s1_vhigh != volt_reg)
        begin
            if (st_new == btcg_pkg::TH_HIGH)
            begin
                emit = 1'b1;
            end
            if (cfg.version == btcg_pkg::VER_V21 && st_new == btcg_pkg::TH_COOL)
            begin
                emit = 1'b1;
            end
        end
    end

    // Build the votes and health
    always_comb
    begin
        fcc_c    = btcg_pkg::NO_VOTE_MA;
        vfl_c    = btcg_pkg::NO_VOTE_MV;
        health_c = btcg_pkg::HEALTH_GOOD;
        unique case (st_new)
            btcg_pkg::TH_COLD, btcg_pkg::TH_OVERHEAT:
            begin
                fcc_c = 13'sd0;
            end
            btcg_pkg::TH_HIGH:
            begin
                fcc_c = 13'sd0;
                if (!s1_vhigh)
                begin
                    fcc_c = 13'(cfg.fcc_limit_ma);
                    if (cfg.version >= btcg_pkg::VER_V20)
                    begin
                        vfl_c = 14'(cfg.vfloat_limit_mv);
                    end
                end
            end
            btcg_pkg::TH_COOL:
            begin
                if (cfg.version >= btcg_pkg::VER_V19)
                begin
                    fcc_c = 13'(cfg.fcc_limit_ma);
                end
                if (cfg.version == btcg_pkg::VER_V21 && s1_vhigh)
                begin
                    fcc_c = btcg_pkg::COOL_HV_FCC;
                end
            end
            default:
            begin
                // normal casts no vote
            end
        endcase
        if (cfg.version >= btcg_pkg::VER_V20)
        begin
            if (st_new == btcg_pkg::TH_OVERHEAT)
            begin
                health_c = btcg_pkg::HEALTH_OVERHEAT;
            end
            else if (st_new == btcg_pkg::TH_COLD)
            begin
                health_c = btcg_pkg::HEALTH_COLD;
            end
        end
    end

    // Next state and result valid
    always_comb
    begin
        thermal_next   = update ? st_new : thermal_reg;
        volt_next      = update ? s1_vhigh : volt_reg;
        out_valid_next = out_valid_reg;
        if (update && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thermal_reg   <= btcg_pkg::TH_NORMAL;
            volt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thermal_reg   <= thermal_next;
            volt_reg      <= volt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (update && emit)
        begin
            o_state_reg  <= st_new;
            o_vhigh_reg  <= s1_vhigh;
            o_health_reg <= health_c;
            o_fcc_reg    <= fcc_c;
            o_vfl_reg    <= vfl_c;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.thermal_state   = o_state_reg;
    assign result.voltage_high    = o_vhigh_reg;
    assign result.health          = o_health_reg;
    assign result.current_vote_ma = o_fcc_reg;
    assign result.float_vote_mv   = o_vfl_reg;

    // A pending request always mirrors the live state
    `BTCG_ASSERT(a_out_matches_state, out_valid_reg |-> (o_state_reg == thermal_reg && o_vhigh_reg == volt_reg))
    // Disabled versions leave the state alone
    `BTCG_ASSERT(a_bad_version_holds, (advance && !ver_ok) |=> $stable(thermal_reg))
    // No vote only in normal or cool
    `BTCG_ASSERT(a_no_vote_levels, (out_valid_reg && o_fcc_reg == btcg_pkg::NO_VOTE_MA) |-> (o_state_reg == btcg_pkg::TH_NORMAL || o_state_reg == btcg_pkg::TH_COOL))
    // Health is reported by the newer rule sets only
    `BTCG_ASSERT(a_health_version, (out_valid_reg && o_health_reg != btcg_pkg::HEALTH_GOOD) |-> (cfg.version >= btcg_pkg::VER_V20))
    // Result register comes out of reset empty
    `BTCG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_reg || rst_n)

endmodule

// File: hdl/battery_thermal_charge_guard_unit.sv
// Battery thermal charge guard. Takes one battery sample (temperature in 0.1 degC,
// voltage in uV) per clock unless the result channel stalls; tracks a five-level
// thermal state with hysteresis plus a voltage-high flag. A result (state, voltage
// flag, health, current vote, float vote, -1 = no vote) comes out only when the change
// matters. A sample is registered, then the state update and result are computed into
// the result register; one sample per cycle unless the result stalls. Registers on
// the APB port (byte address 4*i): version, fcc_limit_ma, vfloat_limit_mv; limits
// saturate at write, versions 5..7 drop samples. Write them only while the block is idle.
module battery_thermal_charge_guard_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    btcg_sample_if.sink                  sample,
    btcg_result_if.source                result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [btcg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    btcg_pkg::cfg_t     cfg;
    logic               advance;
    logic               s1_valid;
    logic signed [10:0] s1_temp;
    logic               s1_vhigh;

    btcg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btcg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .vthr_uv  (cfg.vthr_uv),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_temp  (s1_temp),
        .s1_vhigh (s1_vhigh)
    );

    btcg_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_temp  (s1_temp),
        .s1_vhigh (s1_vhigh),
        .advance  (advance),
        .result   (result)
    );

endmodule
